[rtl/core/sst_pkg.sv]
// Package for the swap slot table: field widths, table size, function codes,
// controller states and the memory write word.
// No dependencies.
package sst_pkg;

    localparam int NUM_SLOTS = 2048;
    localparam int ADDR_W    = $clog2(NUM_SLOTS);
    localparam int PTR_W     = ADDR_W + 1;      // holds NUM_SLOTS itself

    localparam int FUNC_W    = 3;
    localparam int SLOT_W    = 11;
    localparam int PAGE_W    = 20;
    localparam int PID_W     = 6;
    localparam int CNT_W     = 12;
    localparam int TAG_W     = PAGE_W + PID_W;
    localparam int ENTRY_W   = TAG_W + 1;       // {free, page, pid}

    typedef enum logic [FUNC_W-1:0] {
        FN_FIND_FREE   = 3'd0,
        FN_STORE       = 3'd1,
        FN_RELEASE     = 3'd2,
        FN_LOOKUP      = 3'd3,
        FN_RELEASE_ALL = 3'd4,
        FN_FORK        = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_FSRC,
        ST_FFREE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [ENTRY_W-1:0] data;
    } ram_wr_t;

endpackage

[rtl/core/sst_ram.sv]
// Slot memory: one entry per slot holding {free, page, pid}.
// One write and one read port, read data registered. Uses sst_pkg.
module sst_ram (
    input  logic                         aclk,
    input  sst_pkg::ram_wr_t             wr,
    input  logic                         rd_en,
    input  logic [sst_pkg::ADDR_W-1:0]   rd_addr,
    output logic [sst_pkg::ENTRY_W-1:0]  rd_data
);

    logic [sst_pkg::ENTRY_W-1:0] mem [sst_pkg::NUM_SLOTS];
    logic [sst_pkg::ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/swap_slot_table_core.sv]
// Swap slot table top level: controller, scan pointers and output register.
// Depends on sst_pkg and sst_ram.
//
//  channel | ports                                                   | dir
//  --------+---------------------------------------------------------+----
//  s_      | valid/ready, func, slot, vpage, pid, dest_pid           | in
//  m_      | valid/ready, result_slot, hit, out_of_space, copied_count | out
//
// After reset a clearing pass marks all NUM_SLOTS entries free;
// s_ready stays low during it.
// store, release: one write, then the response; unused codes go straight to the response.
// find_free, lookup, release_all: one memory read per cycle on the scan pointer.
// fork: copies each slot of pid to dest_pid until it runs out of space;
// source and free pointers share the read port, and each switch between them
// restarts the read on the other pointer.
// A word waiting on m_ stalls only the final handoff; the next word is taken
// while it waits.
module swap_slot_table_core (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [sst_pkg::FUNC_W-1:0]   s_func,
    input  logic [sst_pkg::SLOT_W-1:0]   s_slot,
    input  logic [sst_pkg::PAGE_W-1:0]   s_vpage,
    input  logic [sst_pkg::PID_W-1:0]    s_pid,
    input  logic [sst_pkg::PID_W-1:0]    s_dest_pid,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sst_pkg::SLOT_W-1:0]   m_result_slot,
    output logic                         m_hit,
    output logic                         m_out_of_space,
    output logic [sst_pkg::CNT_W-1:0]    m_copied_count
);

    localparam int AW = sst_pkg::ADDR_W;
    localparam int PW = sst_pkg::PTR_W;
    localparam logic [PW-1:0] PTR_END = PW'(sst_pkg::NUM_SLOTS);

    sst_pkg::state_t state_reg, state_next;

    logic [sst_pkg::FUNC_W-1:0]  func_reg, func_next;
    logic [sst_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [sst_pkg::PAGE_W-1:0]  page_reg, page_next;
    logic [sst_pkg::PID_W-1:0]   pid_reg, pid_next;
    logic [sst_pkg::PID_W-1:0]   dpid_reg, dpid_next;

    logic [PW-1:0]               ptr_reg, ptr_next;
    logic [PW-1:0]               src_reg, src_next;
    logic [PW-1:0]               free_reg, free_next;
    logic                        dvld_reg, dvld_next;
    logic [AW-1:0]               daddr_reg, daddr_next;
    logic [sst_pkg::PAGE_W-1:0]  hold_page_reg, hold_page_next;

    logic [sst_pkg::SLOT_W-1:0]  res_slot_reg, res_slot_next;
    logic                        res_hit_reg, res_hit_next;
    logic                        res_oos_reg, res_oos_next;
    logic [sst_pkg::CNT_W-1:0]   res_cnt_reg, res_cnt_next;

    logic                        m_valid_reg, m_valid_next;
    logic [sst_pkg::SLOT_W-1:0]  m_slot_reg, m_slot_next;
    logic                        m_hit_reg, m_hit_next;
    logic                        m_oos_reg, m_oos_next;
    logic [sst_pkg::CNT_W-1:0]   m_cnt_reg, m_cnt_next;

    sst_pkg::ram_wr_t            mem_wr;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [sst_pkg::ENTRY_W-1:0] rd_data;

    sst_ram u_ram (
        .aclk    (aclk),
        .wr      (mem_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // decode of the word coming back from memory
    logic                        d_free;
    logic [sst_pkg::PAGE_W-1:0]  d_page;
    logic [sst_pkg::PID_W-1:0]   d_pid;
    logic                        can_issue;
    logic                        scan_end;
    logic                        out_free;
    logic                        s_fire;
    logic                        find_hit;
    logic                        lookup_hit;
    logic                        pid_hit;
    logic                        free_hit;
    logic                        slot_ok;
    sst_pkg::func_t              func_c;
    sst_pkg::func_t              s_func_c;
    logic [PW-1:0]               daddr_inc;

    assign d_free    = rd_data[sst_pkg::ENTRY_W-1];
    assign d_page    = rd_data[sst_pkg::TAG_W-1:sst_pkg::PID_W];
    assign d_pid     = rd_data[sst_pkg::PID_W-1:0];
    assign can_issue = (ptr_reg < PTR_END);
    assign scan_end  = !dvld_reg && !can_issue;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == sst_pkg::ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign func_c    = sst_pkg::func_t'(func_reg);
    assign s_func_c  = sst_pkg::func_t'(s_func);
    assign daddr_inc = PW'({1'b0, daddr_reg} + PW'(1));
    assign slot_ok   = (PW'(slot_reg) < PTR_END);

    assign find_hit   = dvld_reg && d_free && (func_c == sst_pkg::FN_FIND_FREE);
    assign lookup_hit = dvld_reg && !d_free && (func_c == sst_pkg::FN_LOOKUP)
                        && (d_page == page_reg) && (d_pid == pid_reg);
    assign pid_hit    = dvld_reg && !d_free && (d_pid == pid_reg);
    assign free_hit   = dvld_reg && d_free;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sst_pkg::ST_CLEAR: begin
                if (ptr_reg == PTR_END - PW'(1)) begin
                    state_next = sst_pkg::ST_IDLE;
                end
            end
            sst_pkg::ST_IDLE: begin
                if (s_fire) begin
                    unique case (s_func_c)
                        sst_pkg::FN_FIND_FREE,
                        sst_pkg::FN_LOOKUP,
                        sst_pkg::FN_RELEASE_ALL: state_next = sst_pkg::ST_SCAN;
                        sst_pkg::FN_STORE,
                        sst_pkg::FN_RELEASE:     state_next = sst_pkg::ST_WRITE;
                        sst_pkg::FN_FORK:        state_next = sst_pkg::ST_FSRC;
                        default:                 state_next = sst_pkg::ST_RESP;
                    endcase
                end
            end
            sst_pkg::ST_WRITE: state_next = sst_pkg::ST_RESP;
            sst_pkg::ST_SCAN: begin
                if (find_hit || lookup_hit || scan_end) begin
                    state_next = sst_pkg::ST_RESP;
                end
            end
            sst_pkg::ST_FSRC: begin
                priority if (pid_hit) begin
                    state_next = sst_pkg::ST_FFREE;
                end else if (scan_end) begin
                    state_next = sst_pkg::ST_RESP;
                end
            end
            sst_pkg::ST_FFREE: begin
                priority if (free_hit) begin
                    state_next = sst_pkg::ST_FSRC;
                end else if (scan_end) begin
                    state_next = sst_pkg::ST_RESP;
                end
            end
            sst_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = sst_pkg::ST_IDLE;
                end
            end
            default: state_next = sst_pkg::ST_CLEAR;
        endcase
    end

    // datapath and memory control
    always_comb begin
        func_next      = func_reg;
        slot_next      = slot_reg;
        page_next      = page_reg;
        pid_next       = pid_reg;
        dpid_next      = dpid_reg;
        ptr_next       = ptr_reg;
        src_next       = src_reg;
        free_next      = free_reg;
        dvld_next      = 1'b0;
        daddr_next     = daddr_reg;
        hold_page_next = hold_page_reg;
        res_slot_next  = res_slot_reg;
        res_hit_next   = res_hit_reg;
        res_oos_next   = res_oos_reg;
        res_cnt_next   = res_cnt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_slot_next    = m_slot_reg;
        m_hit_next     = m_hit_reg;
        m_oos_next     = m_oos_reg;
        m_cnt_next     = m_cnt_reg;
        mem_wr         = '0;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg[AW-1:0];

        // pointer walk shared by all scans: one read per cycle, unless fork is switching pointers
        if ((state_reg == sst_pkg::ST_SCAN || state_reg == sst_pkg::ST_FSRC ||
             state_reg == sst_pkg::ST_FFREE) && can_issue) begin
            rd_en      = 1'b1;
            ptr_next   = ptr_reg + PW'(1);
            dvld_next  = 1'b1;
            daddr_next = ptr_reg[AW-1:0];
        end

        unique case (state_reg)
            sst_pkg::ST_CLEAR: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = ptr_reg[AW-1:0];
                mem_wr.data = {1'b1, {sst_pkg::TAG_W{1'b0}}};
                ptr_next    = ptr_reg + PW'(1);
            end
            sst_pkg::ST_IDLE: begin
                if (s_fire) begin
                    func_next     = s_func;
                    slot_next     = s_slot;
                    page_next     = s_vpage;
                    pid_next      = s_pid;
                    dpid_next     = s_dest_pid;
                    ptr_next      = '0;
                    src_next      = '0;
                    free_next     = '0;
                    res_slot_next = '0;
                    res_hit_next  = 1'b0;
                    res_oos_next  = 1'b0;
                    res_cnt_next  = '0;
                end
            end
            sst_pkg::ST_WRITE: begin
                mem_wr.addr = slot_reg[AW-1:0];
                if (func_c == sst_pkg::FN_STORE) begin
                    mem_wr.en   = slot_ok;
                    mem_wr.data = {1'b0, page_reg, pid_reg};
                end else begin
                    // a free slot's tag is never looked at
                    mem_wr.en   = slot_ok;
                    mem_wr.data = {1'b1, {sst_pkg::TAG_W{1'b0}}};
                end
            end
            sst_pkg::ST_SCAN: begin
                if (find_hit || lookup_hit) begin
                    res_slot_next = sst_pkg::SLOT_W'(daddr_reg);
                    res_hit_next  = 1'b1;
                end
                if (func_c == sst_pkg::FN_RELEASE_ALL && pid_hit) begin
                    mem_wr.en   = 1'b1;
                    mem_wr.addr = daddr_reg;
                    mem_wr.data = {1'b1, d_page, d_pid};
                end
            end
            sst_pkg::ST_FSRC: begin
                if (pid_hit) begin
                    // park the source scan, hunt for a free slot from free_reg
                    src_next       = daddr_inc;
                    hold_page_next = d_page;
                    ptr_next       = free_reg;
                    dvld_next      = 1'b0;
                    rd_en          = 1'b0;
                end
            end
            sst_pkg::ST_FFREE: begin
                priority if (free_hit) begin
                    mem_wr.en    = 1'b1;
                    mem_wr.addr  = daddr_reg;
                    mem_wr.data  = {1'b0, hold_page_reg, dpid_reg};
                    res_cnt_next = res_cnt_reg + sst_pkg::CNT_W'(1);
                    free_next    = daddr_inc;
                    ptr_next     = src_reg;
                    dvld_next    = 1'b0;
                    rd_en        = 1'b0;
                end else if (scan_end) begin
                    res_oos_next = 1'b1;
                end
            end
            sst_pkg::ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_slot_next  = res_slot_reg;
                    m_hit_next   = res_hit_reg;
                    m_oos_next   = res_oos_reg;
                    m_cnt_next   = res_cnt_reg;
                end
            end
            default: begin
                ptr_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sst_pkg::ST_CLEAR;
            ptr_reg     <= '0;
            dvld_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            dvld_reg    <= dvld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        slot_reg      <= slot_next;
        page_reg      <= page_next;
        pid_reg       <= pid_next;
        dpid_reg      <= dpid_next;
        src_reg       <= src_next;
        free_reg      <= free_next;
        daddr_reg     <= daddr_next;
        hold_page_reg <= hold_page_next;
        res_slot_reg  <= res_slot_next;
        res_hit_reg   <= res_hit_next;
        res_oos_reg   <= res_oos_next;
        res_cnt_reg   <= res_cnt_next;
        m_slot_reg    <= m_slot_next;
        m_hit_reg     <= m_hit_next;
        m_oos_reg     <= m_oos_next;
        m_cnt_reg     <= m_cnt_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_slot  = m_slot_reg;
    assign m_hit          = m_hit_reg;
    assign m_out_of_space = m_oos_reg;
    assign m_copied_count = m_cnt_reg;

    // reset always restarts the clearing pass from slot 0
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> (state_reg == sst_pkg::ST_CLEAR && ptr_reg == '0))
        else $error("reset did not restart clearing pass");

    // clearing pass ends after the last slot
    a_clear_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sst_pkg::ST_CLEAR && ptr_reg == PTR_END - PW'(1))
        |=> state_reg == sst_pkg::ST_IDLE)
        else $error("clearing pass did not end at last slot");

    // a read never targets the entry being written in the same cycle
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_wr.en && rd_en) |-> (mem_wr.addr != rd_addr))
        else $error("read and write to the same entry");

    // out of space and a found slot never come together
    a_oos_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_oos_reg && (m_hit_reg || m_slot_reg != '0)))
        else $error("out_of_space word carries a slot");

endmodule
